FILE: hdl/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result kinds,
// error codes, opcodes and the result record shared by all modules.
// No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN16   = 3'd1,
    PH_LEN64   = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  localparam logic [2:0] KIND_ABSORB  = 3'd0;
  localparam logic [2:0] KIND_HDR_OK  = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_ERROR   = 3'd3;
  localparam logic [2:0] KIND_IGNORED = 3'd4;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_UNMASKED    = 4'd1;
  localparam logic [3:0] ERR_BAD_LEN16   = 4'd2;
  localparam logic [3:0] ERR_BAD_LEN64   = 4'd3;
  localparam logic [3:0] ERR_FRAG_CTRL   = 4'd4;
  localparam logic [3:0] ERR_CTRL_LONG   = 4'd5;
  localparam logic [3:0] ERR_EXP_CONT    = 4'd6;
  localparam logic [3:0] ERR_UNEXP_CONT  = 4'd7;
  localparam logic [3:0] ERR_BAD_OPCODE  = 4'd8;

  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'h7d;
  localparam logic [63:0] LEN16_MIN    = 64'h7d;
  localparam logic [63:0] LEN64_MIN    = 64'hffff;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_out;
    logic [3:0]  opcode;
    logic        fin;
    logic [62:0] frame_length;
    logic        last_of_frame;
    logic [3:0]  error_code;
  } result_t;

endpackage

FILE: hdl/wsd_parser.sv
// Frame parser: phase register, header/length/key registers and the
// single-pass next-state and result logic for one byte. Uses wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_in,
  output wsd_pkg::result_t res
);

  wsd_pkg::phase_t phase, phase_next;
  logic [2:0]  cnt, cnt_next;
  logic [62:0] remaining, remaining_next;
  logic [63:0] length_shift, length_shift_next;
  logic [31:0] mask_key, mask_key_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic        frame_fin, frame_fin_next;
  logic        fragment_open, fragment_open_next;
  logic [3:0]  error_latch, error_latch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wsd_pkg::PH_HEADER;
      cnt           <= '0;
      remaining     <= '0;
      length_shift  <= '0;
      mask_key      <= '0;
      frame_opcode  <= '0;
      frame_fin     <= 1'b0;
      fragment_open <= 1'b0;
      error_latch   <= wsd_pkg::ERR_NONE;
    end else if (advance) begin
      phase         <= phase_next;
      cnt           <= cnt_next;
      remaining     <= remaining_next;
      length_shift  <= length_shift_next;
      mask_key      <= mask_key_next;
      frame_opcode  <= frame_opcode_next;
      frame_fin     <= frame_fin_next;
      fragment_open <= fragment_open_next;
      error_latch   <= error_latch_next;
    end
  end

  logic [15:0] len16;
  logic [63:0] len64;
  logic [31:0] key_shifted;
  logic [3:0]  frame_err;
  logic        frag_after;
  logic [7:0]  key_byte;
  logic [2:0]  kind;
  logic [7:0]  dout;
  logic        last;
  logic [3:0]  err;

  assign len16       = {length_shift[7:0], data_in};
  assign len64       = {length_shift[55:0], data_in};
  assign key_shifted = {mask_key[23:0], data_in};

  always_comb begin
    frame_err  = wsd_pkg::ERR_NONE;
    frag_after = fragment_open;
    if (frame_opcode inside {wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG}) begin
      if (!frame_fin) begin
        frame_err = wsd_pkg::ERR_FRAG_CTRL;
      end else if (length_shift > wsd_pkg::CTRL_MAX_LEN) begin
        frame_err = wsd_pkg::ERR_CTRL_LONG;
      end
    end else if (frame_opcode inside {wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN}) begin
      if (fragment_open) begin
        frame_err = wsd_pkg::ERR_EXP_CONT;
      end else begin
        frag_after = !frame_fin;
      end
    end else if (frame_opcode == wsd_pkg::OP_CONT) begin
      if (!fragment_open) begin
        frame_err = wsd_pkg::ERR_UNEXP_CONT;
      end else if (frame_fin) begin
        frag_after = 1'b0;
      end
    end else begin
      frame_err = wsd_pkg::ERR_BAD_OPCODE;
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    cnt_next           = cnt;
    remaining_next     = remaining;
    length_shift_next  = length_shift;
    mask_key_next      = mask_key;
    frame_opcode_next  = frame_opcode;
    frame_fin_next     = frame_fin;
    fragment_open_next = fragment_open;
    error_latch_next   = error_latch;
    kind               = wsd_pkg::KIND_ABSORB;
    dout               = '0;
    last               = 1'b0;
    err                = wsd_pkg::ERR_NONE;

    case (phase)
      wsd_pkg::PH_ERROR: begin
        kind = wsd_pkg::KIND_IGNORED;
        err  = error_latch;
      end
      wsd_pkg::PH_LEN16: begin
        length_shift_next = {48'd0, len16};
        cnt_next          = cnt + 3'd1;
        if (cnt == 3'd1) begin
          cnt_next = '0;
          if ({48'd0, len16} <= wsd_pkg::LEN16_MIN) begin
            phase_next       = wsd_pkg::PH_ERROR;
            error_latch_next = wsd_pkg::ERR_BAD_LEN16;
            kind             = wsd_pkg::KIND_ERROR;
            err              = wsd_pkg::ERR_BAD_LEN16;
          end else begin
            phase_next = wsd_pkg::PH_MASK;
          end
        end
      end
      wsd_pkg::PH_LEN64: begin
        length_shift_next = len64;
        cnt_next          = cnt + 3'd1;
        if (cnt == 3'd7) begin
          cnt_next = '0;
          if (len64 <= wsd_pkg::LEN64_MIN || len64[63]) begin
            phase_next       = wsd_pkg::PH_ERROR;
            error_latch_next = wsd_pkg::ERR_BAD_LEN64;
            kind             = wsd_pkg::KIND_ERROR;
            err              = wsd_pkg::ERR_BAD_LEN64;
          end else begin
            phase_next = wsd_pkg::PH_MASK;
          end
        end
      end
      wsd_pkg::PH_MASK: begin
        mask_key_next = key_shifted;
        cnt_next      = cnt + 3'd1;
        if (cnt == 3'd3) begin
          cnt_next = '0;
          if (frame_err != wsd_pkg::ERR_NONE) begin
            phase_next       = wsd_pkg::PH_ERROR;
            error_latch_next = frame_err;
            kind             = wsd_pkg::KIND_ERROR;
            err              = frame_err;
          end else begin
            fragment_open_next = frag_after;
            kind               = wsd_pkg::KIND_HDR_OK;
            remaining_next     = length_shift[62:0];
            if (length_shift == '0) begin
              last       = 1'b1;
              phase_next = wsd_pkg::PH_HEADER;
            end else begin
              phase_next = wsd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        kind           = wsd_pkg::KIND_DATA;
        dout           = data_in ^ key_byte;
        cnt_next       = cnt + 3'd1;
        remaining_next = remaining - 63'd1;
        if (remaining == 63'd1) begin
          last       = 1'b1;
          cnt_next   = '0;
          phase_next = wsd_pkg::PH_HEADER;
        end
      end
      default: begin
        if (cnt == 3'd0) begin
          frame_fin_next    = data_in[7];
          frame_opcode_next = data_in[3:0];
          cnt_next          = 3'd1;
        end else begin
          length_shift_next = {57'd0, data_in[6:0]};
          mask_key_next     = '0;
          cnt_next          = '0;
          if (!data_in[7]) begin
            phase_next       = wsd_pkg::PH_ERROR;
            error_latch_next = wsd_pkg::ERR_UNMASKED;
            kind             = wsd_pkg::KIND_ERROR;
            err              = wsd_pkg::ERR_UNMASKED;
          end else if (data_in[6:0] == wsd_pkg::LEN7_EXT16) begin
            phase_next = wsd_pkg::PH_LEN16;
          end else if (data_in[6:0] == wsd_pkg::LEN7_EXT64) begin
            phase_next = wsd_pkg::PH_LEN64;
          end else begin
            phase_next = wsd_pkg::PH_MASK;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.kind          = kind;
    res.data_out      = dout;
    res.opcode        = frame_opcode_next;
    res.fin           = frame_fin_next;
    res.frame_length  = length_shift_next[62:0];
    res.last_of_frame = last;
    res.error_code    = err;
  end

endmodule

FILE: hdl/wsd_result_reg.sv
// Result register: holds one finished result until the downstream side
// takes it. Uses wsd_pkg for the result record.
`timescale 1ns / 1ps

module wsd_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t res_in,
  input  logic             take,
  output logic             valid,
  output wsd_pkg::result_t res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

FILE: hdl/websocket_frame_deframer_top.sv
// Channel   Dir  tdata                          tuser      tlast
// s_axis    in   data_in[7:0]                   -          -
// m_axis    out  data_out, opcode, fin,         kind[2:0]  last_of_frame
//                frame_length, error_code
//
// One byte per cycle sustained while m_axis does not stall; a byte's result
// reaches m_axis through the input register, then the result register. The
// parser state advances when the registered byte moves into the result
// register. Reset is synchronous and returns the parser to the header phase
// with no error and no open fragment. A stall on m_axis holds the result
// register and the input register, then back-pressures s_axis.
// Depends on wsd_pkg, wsd_parser and wsd_result_reg.
`timescale 1ns / 1ps

module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_out[7:0], opcode[11:8], fin[12], frame_length[75:13],
  // error_code[79:76], zero[87:80]
  output logic [87:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             load;
  wsd_pkg::result_t res;
  wsd_pkg::result_t out_res;

  assign load          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  wsd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (load),
    .data_in (in_byte),
    .res     (res)
  );

  wsd_result_reg u_result (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .res_in  (res),
    .take    (m_axis_tready),
    .valid   (m_axis_tvalid),
    .res_out (out_res)
  );

  assign m_axis_tdata = {8'd0, out_res.error_code, out_res.frame_length, out_res.fin,
                         out_res.opcode, out_res.data_out};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_of_frame;

`ifndef SYNTH
  a_ignored_has_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == wsd_pkg::KIND_IGNORED |->
      m_axis_tdata[79:76] != wsd_pkg::ERR_NONE)
    else $error("ignored byte without latched error code");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser == wsd_pkg::KIND_DATA || m_axis_tuser == wsd_pkg::KIND_HDR_OK)
    else $error("frame end on a byte that is neither payload nor header");

  a_data_only_payload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != wsd_pkg::KIND_DATA |-> m_axis_tdata[7:0] == 8'd0)
    else $error("nonzero data on a non-payload result");

  a_load_frees_input: assert property (@(posedge clk) disable iff (rst)
    load && !(s_axis_tvalid && s_axis_tready) |=> !in_valid && m_axis_tvalid)
    else $error("input register not released after move to result register");
`endif

endmodule
